### rtl/core/assert_macros.svh
// Assertion macros used by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/lcgpe_pkg.sv
// Shared constants, types and the pulse encoding function of the LED encoder.
package lcgpe_pkg;

  localparam int LED_COUNT = 1024;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic [7:0] PULSE_00 = 8'h88;
  localparam logic [7:0] PULSE_01 = 8'h8E;
  localparam logic [7:0] PULSE_10 = 8'hE8;
  localparam logic [7:0] PULSE_11 = 8'hEE;

  // Pipeline enables and the gamma table write that every lane sees.
  typedef struct packed {
    logic       load_we;
    logic [7:0] load_addr;
    logic [7:0] load_data;
    logic       advance1;
    logic       advance2;
  } lcgpe_lane_ctrl_t;

  function automatic logic [7:0] pulse_of(input logic [1:0] pair);
    logic [7:0] code;
    case (pair)
      2'b00:   code = PULSE_00;
      2'b01:   code = PULSE_01;
      2'b10:   code = PULSE_10;
      default: code = PULSE_11;
    endcase
    return code;
  endfunction

  // Most significant bit pair goes out first, in bits 31:24.
  function automatic logic [31:0] encode_byte(input logic [7:0] v);
    return {pulse_of(v[7:6]), pulse_of(v[5:4]), pulse_of(v[3:2]), pulse_of(v[1:0])};
  endfunction

endpackage

### rtl/core/lcgpe_lane.sv
// One color lane: brightness scaling, gamma lookup and pulse encoding.
module lcgpe_lane
  import lcgpe_pkg::*;
(
  input  logic             clk,
  input  lcgpe_lane_ctrl_t ctrl,
  input  logic [7:0]       level,
  input  logic [7:0]       brightness,
  output logic [31:0]      code
);

  logic [15:0] product;
  logic [16:0] div_sum;
  logic [7:0]  scaled;
  logic [7:0]  gamma_mem [256];
  logic [7:0]  corrected;

  always_ff @(posedge clk) begin
    if (ctrl.advance1) begin
      product <= {8'b0, level} * {8'b0, brightness};
    end
  end

  // floor(p / 255) = (p + 1 + (p >> 8)) >> 8, exact for every product of two bytes.
  assign div_sum = {1'b0, product} + 17'd1 + {9'b0, product[15:8]};
  assign scaled  = div_sum[15:8];

  // Each lane keeps its own copy of the table so all three colors read in parallel.
  always_ff @(posedge clk) begin
    if (ctrl.load_we) begin
      gamma_mem[ctrl.load_addr] <= ctrl.load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance2) begin
      corrected <= gamma_mem[scaled];
    end
  end

  assign code = encode_byte(corrected);

endmodule

### rtl/core/lcgpe_merge.sv
// Output stage that joins the three lane codes and the LED position.
module lcgpe_merge
  import lcgpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        lane_valid,
  output logic        lane_ready,
  input  logic [9:0]  lane_position,
  input  logic [31:0] lane_green,
  input  logic [31:0] lane_red,
  input  logic [31:0] lane_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  led_position,
  output logic [31:0] green_code,
  output logic [31:0] red_code,
  output logic [31:0] blue_code
);

  assign lane_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ready) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready) begin
      led_position <= lane_position;
      green_code   <= lane_green;
      red_code     <= lane_red;
      blue_code    <= lane_blue;
    end
  end

endmodule

### rtl/core/led_color_gamma_pulse_encoder_top.sv
// Top level of the LED color gamma pulse encoder.
// Input channel (in_valid/in_ready) carries either a gamma table load
// (command low: table_index, table_value) or an LED color to encode
// (command high: led_index and the three raw levels).
// Output channel (out_valid/out_ready) returns one transaction per encode:
// led_position and the green, red and blue pulse words, first byte in 31:24.
// brightness_we writes brightness_wdata into the brightness register at once;
// write it only while no encode is in flight.
// An encode passes the multiply, gamma read and output registers before it
// shows on out_valid. Throughput is one transaction per clock while the
// receiver does not stall, set by the three-stage pipeline (multiply, gamma
// memory read, output register) and a separate gamma memory in each color lane.
// A load takes effect for every encode accepted after it and returns nothing.
// Reset clears the pipeline valid flags and sets brightness to 255; the gamma
// table is not cleared and must be loaded before use.
// When the receiver stalls, results queue in the pipeline stages; input is
// refused only once every stage holds a transaction.
`include "assert_macros.svh"
module led_color_gamma_pulse_encoder_top
  import lcgpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        brightness_we,
  input  logic [7:0]  brightness_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  table_index,
  input  logic [7:0]  table_value,
  input  logic [9:0]  led_index,
  input  logic [7:0]  red_level,
  input  logic [7:0]  green_level,
  input  logic [7:0]  blue_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  led_position,
  output logic [31:0] green_code,
  output logic [31:0] red_code,
  output logic [31:0] blue_code
);

  logic             [7:0]  brightness;
  logic                    accept;
  logic                    enc_accept;
  logic                    merge_ready;
  logic                    ready1;
  logic                    ready2;
  logic                    v1;
  logic                    v2;
  logic             [9:0]  led1;
  logic             [9:0]  led2;
  lcgpe_lane_ctrl_t        ctrl;
  logic             [31:0] green_lane;
  logic             [31:0] red_lane;
  logic             [31:0] blue_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 8'd255;
    end else if (brightness_we) begin
      brightness <= brightness_wdata;
    end
  end

  assign ready2   = !v2 || merge_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  assign accept     = in_valid && in_ready;
  assign enc_accept = accept && (command == CMD_ENCODE) && (32'(led_index) < LED_COUNT);

  assign ctrl.load_we   = accept && (command == CMD_LOAD);
  assign ctrl.load_addr = table_index;
  assign ctrl.load_data = table_value;
  assign ctrl.advance1  = ready1;
  assign ctrl.advance2  = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= enc_accept;
      end
      if (ready2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      led1 <= led_index;
    end
    if (ready2) begin
      led2 <= led1;
    end
  end

  lcgpe_lane u_green (
    .clk        (clk),
    .ctrl       (ctrl),
    .level      (green_level),
    .brightness (brightness),
    .code       (green_lane)
  );

  lcgpe_lane u_red (
    .clk        (clk),
    .ctrl       (ctrl),
    .level      (red_level),
    .brightness (brightness),
    .code       (red_lane)
  );

  lcgpe_lane u_blue (
    .clk        (clk),
    .ctrl       (ctrl),
    .level      (blue_level),
    .brightness (brightness),
    .code       (blue_lane)
  );

  lcgpe_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .lane_valid    (v2),
    .lane_ready    (merge_ready),
    .lane_position (led2),
    .lane_green    (green_lane),
    .lane_red      (red_lane),
    .lane_blue     (blue_lane),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .led_position  (led_position),
    .green_code    (green_code),
    .red_code      (red_code),
    .blue_code     (blue_code)
  );

  // A load never puts a transaction into the pipeline.
  `ASSERT_NEXT(a_load_no_result, ctrl.load_we, !v1)
  // An accepted encode always occupies the first stage.
  `ASSERT_NEXT(a_encode_enters, enc_accept, v1)
  // A stalled first stage keeps its transaction and its LED position.
  `ASSERT_NEXT(a_stage1_holds, v1 && !ready2, v1 && $stable(led1))
  // A second-stage transaction moving on always reaches the output register.
  `ASSERT_NEXT(a_stage2_to_out, v2 && merge_ready, out_valid)

endmodule

### test/led_code_checker.sv
// Checker that predicts and compares the pulse words of the LED color encoder.
`timescale 1ns / 1ps
module led_code_checker
  import lcgpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        brightness_we,
  input  logic [7:0]  brightness_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [7:0]  table_index,
  input  logic [7:0]  table_value,
  input  logic [9:0]  led_index,
  input  logic [7:0]  red_level,
  input  logic [7:0]  green_level,
  input  logic [7:0]  blue_level,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  led_position,
  input  logic [31:0] green_code,
  input  logic [31:0] red_code,
  input  logic [31:0] blue_code,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [9:0]  led;
    logic [31:0] green;
    logic [31:0] red;
    logic [31:0] blue;
  } led_code_t;

  logic [7:0] gamma_copy [256];
  logic [7:0] bright;
  led_code_t  expected_codes [$];

  // Brightness scaling then gamma lookup.
  function automatic logic [7:0] corrected_level(input logic [7:0] level);
    logic [15:0] product;
    logic [15:0] scaled;
    product = level * bright;
    scaled = product / 16'd255;
    return gamma_copy[scaled[7:0]];
  endfunction

  function automatic logic [31:0] pulse_word(input logic [7:0] v);
    logic [31:0] word;
    logic [1:0]  pair;
    for (int i = 0; i < 4; i++) begin
      pair = v[7 - 2 * i -: 2];
      case (pair)
        2'b00:   word[31 - 8 * i -: 8] = PULSE_00;
        2'b01:   word[31 - 8 * i -: 8] = PULSE_01;
        2'b10:   word[31 - 8 * i -: 8] = PULSE_10;
        default: word[31 - 8 * i -: 8] = PULSE_11;
      endcase
    end
    return word;
  endfunction

  always @(posedge clk) begin
    led_code_t seen;
    led_code_t want;
    if (rst) begin
      bright = 8'd255;
      expected_codes.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{led_position, green_code, red_code, blue_code};
        if (expected_codes.size() == 0) begin
          $error("unexpected output transaction: led_position %0d", led_position);
          fail_count++;
        end else begin
          want = expected_codes.pop_front();
          if (seen.led !== want.led) begin
            $error("led_position: expected %0d, actual %0d", want.led, seen.led);
            fail_count++;
          end
          if (seen.green !== want.green) begin
            $error("green_code: expected %h, actual %h", want.green, seen.green);
            fail_count++;
          end
          if (seen.red !== want.red) begin
            $error("red_code: expected %h, actual %h", want.red, seen.red);
            fail_count++;
          end
          if (seen.blue !== want.blue) begin
            $error("blue_code: expected %h, actual %h", want.blue, seen.blue);
            fail_count++;
          end
        end
      end
      if (brightness_we)
        bright = brightness_wdata;
      if (in_valid && in_ready) begin
        if (command == CMD_LOAD) begin
          gamma_copy[table_index] = table_value;
        end else if (led_index < LED_COUNT) begin
          want.led = led_index;
          want.green = pulse_word(corrected_level(green_level));
          want.red = pulse_word(corrected_level(red_level));
          want.blue = pulse_word(corrected_level(blue_level));
          expected_codes.push_back(want);
        end
      end
    end
    pending = expected_codes.size();
  end

endmodule

### test/led_color_gamma_pulse_encoder_top_tb.sv
// Testbench top: stimulus, flow control and verdict for the LED color encoder.
`timescale 1ns / 1ps
module led_color_gamma_pulse_encoder_top_tb;
  import lcgpe_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        brightness_we = 1'b0;
  logic [7:0]  brightness_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_LOAD;
  logic [7:0]  table_index = 8'd0;
  logic [7:0]  table_value = 8'd0;
  logic [9:0]  led_index = 10'd0;
  logic [7:0]  red_level = 8'd0;
  logic [7:0]  green_level = 8'd0;
  logic [7:0]  blue_level = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [9:0]  led_position;
  logic [31:0] green_code;
  logic [31:0] red_code;
  logic [31:0] blue_code;

  int fail_count;
  int pending;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  led_color_gamma_pulse_encoder_top dut (
    .clk(clk), .rst(rst),
    .brightness_we(brightness_we), .brightness_wdata(brightness_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .table_index(table_index), .table_value(table_value),
    .led_index(led_index), .red_level(red_level), .green_level(green_level),
    .blue_level(blue_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_position(led_position), .green_code(green_code), .red_code(red_code),
    .blue_code(blue_code)
  );

  led_code_checker checker_i (
    .clk(clk), .rst(rst),
    .brightness_we(brightness_we), .brightness_wdata(brightness_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .table_index(table_index), .table_value(table_value),
    .led_index(led_index), .red_level(red_level), .green_level(green_level),
    .blue_level(blue_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_position(led_position), .green_code(green_code), .red_code(red_code),
    .blue_code(blue_code),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                           input logic [9:0] led, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    command = cmd;
    table_index = idx;
    table_value = val;
    led_index = led;
    red_level = r;
    green_level = g;
    blue_level = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
    send_item(CMD_LOAD, idx, val, 10'($urandom_range(0, 1023)),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic encode_led(input logic [9:0] led, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    send_item(CMD_ENCODE, 8'($urandom), 8'($urandom), led, r, g, b);
  endtask

  // Stop offering input, wait for every result, then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_brightness(input logic [7:0] value);
    wait_drained();
    brightness_we = 1'b1;
    brightness_wdata = value;
    @(negedge clk);
    brightness_we = 1'b0;
    brightness_wdata = 8'($urandom);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 4) == 0)
      load_entry(8'($urandom), 8'($urandom));
    else
      encode_led(10'($urandom_range(0, 1023)), rand_level(), rand_level(), rand_level());
  endtask

  initial begin
    logic [7:0] phase_bright [8];
    phase_bright = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'($urandom), 8'($urandom), 8'd255};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The gamma table has no reset value, so every entry is filled first.
    for (int i = 0; i < 256; i++)
      load_entry(8'(i), 8'($urandom));

    load_entry(8'hFF, 8'hE4);
    load_entry(8'h00, 8'h1B);
    encode_led(10'd1023, 8'd255, 8'd255, 8'd255);
    encode_led(10'd0, 8'd0, 8'd0, 8'd0);
    encode_led(10'd512, 8'd0, 8'd255, 8'd128);
    load_entry(8'h80, 8'hFF);
    encode_led(10'd5, 8'd128, 8'd128, 8'd128);
    load_entry(8'h80, 8'h00);
    encode_led(10'd6, 8'd128, 8'd0, 8'd255);
    load_entry(8'h55, 8'h55);
    load_entry(8'hAA, 8'hAA);
    encode_led(10'd341, 8'h55, 8'hAA, 8'h01);
    encode_led(10'd682, 8'hAA, 8'h55, 8'hFF);
    encode_led(10'd1, 8'd1, 8'd2, 8'd3);
    encode_led(10'd1022, 8'd254, 8'd127, 8'd64);

    for (int p = 0; p < 8; p++) begin
      if (p > 0)
        set_brightness(phase_bright[p]);
      if (p == 7)
        quiet = 1'b1;
      for (int n = 0; n < 155; n++) begin
        if (p == 2 && n == 40)
          hold_req = 1'b1;
        if (p == 3 && n == 95)
          wait_drained();
        random_item();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
